>>> rtl/core/cdat_pkg.sv
// Shared types and constants for the CEC device address table.
`default_nettype none

package cdat_pkg;

    localparam int ADDR_W = 16;
    localparam int IDX_W  = 4;
    localparam int PORT_W = 4;

    localparam logic [ADDR_W-1:0] DISABLED_ADDR = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [IDX_W-1:0]     entry_index;
        logic [ADDR_W-1:0]    new_physical;
        logic [PORT_W-1:0]    port_number;
    } t_req;

    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     found_index;
        logic [ADDR_W-1:0]    entry_address;
    } t_table_res;

endpackage

`default_nettype wire

>>> rtl/core/cdat_port_derive.sv
// Child physical address derivation from the own address and a port number.
`default_nettype none

module cdat_port_derive (
    input  logic [cdat_pkg::ADDR_W-1:0] i_own,
    input  logic [cdat_pkg::PORT_W-1:0] i_port,
    output logic [cdat_pkg::ADDR_W-1:0] o_port_address,
    output logic                        o_can_extend
);

    logic [3:0] zero_nib;   // bit 0 is the top nibble
    logic       ext;

    always_comb begin
        zero_nib[0] = (i_own[15:12] == 4'h0);
        zero_nib[1] = (i_own[11:8]  == 4'h0);
        zero_nib[2] = (i_own[7:4]   == 4'h0);
        zero_nib[3] = (i_own[3:0]   == 4'h0);
        // no nonzero nibble after a zero one, and the last nibble is zero
        ext = zero_nib[3] && (!zero_nib[0] || zero_nib[1])
              && (!zero_nib[1] || zero_nib[2]) && (!zero_nib[2] || zero_nib[3]);

        if (!ext) begin
            o_port_address = cdat_pkg::DISABLED_ADDR;
        end else if (zero_nib[0]) begin
            // all zero: port goes into the top nibble
            o_port_address = {i_port, 12'h000};
        end else if (zero_nib[1]) begin
            o_port_address = {i_own[15:12], i_port, 8'h00};
        end else if (zero_nib[2]) begin
            o_port_address = {i_own[15:8], i_port, 4'h0};
        end else begin
            o_port_address = {i_own[15:4], i_port};
        end
        o_can_extend = ext;
    end

endmodule

`default_nettype wire

>>> rtl/core/cdat_table.sv
// Address table storage with write, remove, read and parallel lookup.
`default_nettype none

module cdat_table #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  cdat_pkg::t_req              i_req,
    input  logic [cdat_pkg::ADDR_W-1:0] i_port_address,
    output cdat_pkg::t_table_res        o_res
);

    localparam int SEL_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [cdat_pkg::ADDR_W-1:0] r_table [ENTRIES];

    logic             idx_ok;
    logic [SEL_W-1:0] sel;

    assign idx_ok = ({1'b0, i_req.entry_index} < 5'(ENTRIES));
    assign sel    = i_req.entry_index[SEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_table[i] <= cdat_pkg::DISABLED_ADDR;
            end
        end else if (i_fire && idx_ok) begin
            if (i_req.action == cdat_pkg::ACT_WRITE) begin
                r_table[sel] <= i_req.new_physical;
            end else if (i_req.action == cdat_pkg::ACT_REMOVE) begin
                r_table[sel] <= cdat_pkg::DISABLED_ADDR;
            end
        end
    end

    always_comb begin
        o_res.found         = 1'b0;
        o_res.found_index   = '0;
        o_res.entry_address = cdat_pkg::DISABLED_ADDR;

        if (i_req.action == cdat_pkg::ACT_LOOKUP
                && i_port_address != cdat_pkg::DISABLED_ADDR) begin
            // descending scan leaves the lowest match
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (r_table[i] == i_port_address) begin
                    o_res.found       = 1'b1;
                    o_res.found_index = 4'(i);
                end
            end
        end

        if (idx_ok) begin
            unique case (i_req.action) inside
                cdat_pkg::ACT_WRITE:  o_res.entry_address = i_req.new_physical;
                cdat_pkg::ACT_REMOVE: o_res.entry_address = cdat_pkg::DISABLED_ADDR;
                cdat_pkg::ACT_LOOKUP,
                cdat_pkg::ACT_READ:   o_res.entry_address = r_table[sel];
                default:              o_res.entry_address = cdat_pkg::DISABLED_ADDR;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/cec_device_address_table.sv
// Top level of the CEC device address table: request and result registers.
// Each request passes the request register, then the result register; an output stall holds it back.
// Throughput: one request per cycle unless the output stalls; the table is
// updated as a request leaves the request register, so the next request already sees it.
// Reset (synchronous, active low): all table entries and the own address
// become FFFF, both pipeline registers empty.
`default_nettype none

module cec_device_address_table #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cdat_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [cdat_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [cdat_pkg::ADDR_W-1:0] i_new_physical,
    input  logic [cdat_pkg::PORT_W-1:0] i_port_number,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [cdat_pkg::IDX_W-1:0]  o_found_index,
    output logic [cdat_pkg::ADDR_W-1:0] o_entry_address,
    output logic [cdat_pkg::ADDR_W-1:0] o_port_address,
    output logic                        o_can_extend
);

    logic [cdat_pkg::ADDR_W-1:0] r_own;
    logic                        r_req_valid;
    cdat_pkg::t_req              r_req;
    logic                        r_out_valid;
    cdat_pkg::t_table_res        r_res;
    logic [cdat_pkg::ADDR_W-1:0] r_port_address;
    logic                        r_can_extend;

    logic                        out_free;
    logic                        fire;
    logic                        in_take;
    logic [cdat_pkg::ADDR_W-1:0] port_address;
    logic                        can_extend;
    cdat_pkg::t_table_res        tab_res;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_req_valid && out_free;
    assign o_in_stall  = r_req_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= cdat_pkg::DISABLED_ADDR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_req_valid <= 1'b1;
            end else if (fire) begin
                r_req_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.action       <= cdat_pkg::t_action'(i_action);
            r_req.entry_index  <= i_entry_index;
            r_req.new_physical <= i_new_physical;
            r_req.port_number  <= i_port_number;
        end
        if (fire) begin
            r_res          <= tab_res;
            r_port_address <= port_address;
            r_can_extend   <= can_extend;
        end
    end

    cdat_port_derive u_derive (
        .i_own          (r_own),
        .i_port         (r_req.port_number),
        .o_port_address (port_address),
        .o_can_extend   (can_extend)
    );

    cdat_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_req          (r_req),
        .i_port_address (port_address),
        .o_res          (tab_res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_res.found;
    assign o_found_index   = r_res.found_index;
    assign o_entry_address = r_res.entry_address;
    assign o_port_address  = r_port_address;
    assign o_can_extend    = r_can_extend;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_found_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_port_address != cdat_pkg::DISABLED_ADDR)
        else $error("match reported on disabled address");

    a_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_found_index == '0)
        else $error("found_index nonzero without a match");

    a_no_extend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_can_extend |-> o_port_address == cdat_pkg::DISABLED_ADDR)
        else $error("port address derived from non-extendable own address");

    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("request left without producing a result");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the CEC device address table: directed table plus random traffic.
`timescale 1ns / 1ps

module tb;
    import cdat_pkg::*;

    localparam int LIMIT     = 400000;
    localparam int PHASES    = 10;
    localparam int PHASE_LEN = 155;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  fidx;
        logic [ADDR_W-1:0] entry;
        logic [ADDR_W-1:0] paddr;
        logic              ext;
    } t_result;

    typedef enum logic {ROW_REQ, ROW_OWN} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_action           act;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] newp;
        logic [PORT_W-1:0] port;
        logic              typed;
        t_result           want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic [ADDR_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic [1:0]        i_action = '0;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic [ADDR_W-1:0] i_new_physical = '0;
    logic [PORT_W-1:0] i_port_number = '0;
    logic              i_out_stall = 1'b0;
    logic              drv_typed = 1'b0;
    t_result           drv_want = '0;

    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_found;
    logic [IDX_W-1:0]  o_found_index;
    logic [ADDR_W-1:0] o_entry_address;
    logic [ADDR_W-1:0] o_port_address;
    logic              o_can_extend;

    cec_device_address_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_new_physical  (i_new_physical),
        .i_port_number   (i_port_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_found_index   (o_found_index),
        .o_entry_address (o_entry_address),
        .o_port_address  (o_port_address),
        .o_can_extend    (o_can_extend)
    );

    always #4 i_clk = ~i_clk;

    logic [ADDR_W-1:0] addr_table [16];
    logic [ADDR_W-1:0] own_addr;
    t_result           pending_results [$];
    t_row              directed [$];
    int                errors = 0;
    int                requests = 0;
    int                lookup_hits = 0;
    int                own_settings = 0;
    int                cycles = 0;
    int                in_gap_pct = 0;
    int                out_stall_pct = 0;
    int                stall_left = 0;

    function automatic logic own_extendable(logic [ADDR_W-1:0] a);
        logic zero_seen;
        logic ok;
        int   s;
        zero_seen = 1'b0;
        ok = 1'b1;
        for (s = 3; s >= 0; s--) begin
            if (a[s*4 +: 4] == 4'h0) begin
                zero_seen = 1'b1;
            end else if (zero_seen) begin
                ok = 1'b0;
            end
        end
        return ok && (a[3:0] == 4'h0);
    endfunction

    // Port goes into the first zero nibble that follows a nonzero one, or the top nibble if all are zero.
    function automatic logic [ADDR_W-1:0] child_addr(logic [ADDR_W-1:0] own,
                                                     logic [PORT_W-1:0] port);
        logic [ADDR_W-1:0] r;
        int                s;
        if (!own_extendable(own)) return DISABLED_ADDR;
        if (own == '0) return {port, 12'h000};
        for (s = 2; s >= 0; s--) begin
            if (own[(s+1)*4 +: 4] != 4'h0 && own[s*4 +: 4] == 4'h0) begin
                r = own;
                r[s*4 +: 4] = port;
                return r;
            end
        end
        return own;
    endfunction

    function automatic t_result apply_request(t_action act, logic [IDX_W-1:0] idx,
                                              logic [ADDR_W-1:0] newp,
                                              logic [PORT_W-1:0] port);
        t_result r;
        int      k;
        r = '0;
        r.paddr = child_addr(own_addr, port);
        r.ext = own_extendable(own_addr);
        case (act)
            ACT_WRITE:  addr_table[idx] = newp;
            ACT_REMOVE: addr_table[idx] = DISABLED_ADDR;
            ACT_LOOKUP: begin
                if (r.paddr != DISABLED_ADDR) begin
                    for (k = 15; k >= 0; k--) begin
                        if (addr_table[k] == r.paddr) begin
                            r.found = 1'b1;
                            r.fidx = 4'(k);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.entry = addr_table[idx];
        return r;
    endfunction

    function automatic t_row op(t_action act, logic [3:0] idx, logic [15:0] newp,
                                logic [3:0] port);
        t_row r;
        r = '0;
        r.kind = ROW_REQ;
        r.act = act;
        r.idx = idx;
        r.newp = newp;
        r.port = port;
        return r;
    endfunction

    function automatic t_row op_chk(t_action act, logic [3:0] idx, logic [15:0] newp,
                                    logic [3:0] port, t_result want);
        t_row r;
        r = op(act, idx, newp, port);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_row own_row(logic [15:0] v);
        t_row r;
        r = '0;
        r.kind = ROW_OWN;
        r.newp = v;
        return r;
    endfunction

    // Scoreboard
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) addr_table[k] = DISABLED_ADDR;
            own_addr = DISABLED_ADDR;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                own_addr = i_cfg_data;
                own_settings++;
            end
            if (i_in_valid && !o_in_stall) begin
                exp_r = apply_request(t_action'(i_action), i_entry_index, i_new_physical,
                                      i_port_number);
                if (exp_r.found) lookup_hits++;
                pending_results.push_back(drv_typed ? drv_want : exp_r);
                requests++;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_found, o_found_index, o_entry_address, o_port_address,
                        o_can_extend};
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("%0t unexpected result %p", $time, got);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.found !== exp_r.found || got.fidx !== exp_r.fidx ||
                        got.entry !== exp_r.entry || got.paddr !== exp_r.paddr ||
                        got.ext !== exp_r.ext) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t mismatch exp f=%0d i=%0d e=%h p=%h x=%0d",
                                     $time, exp_r.found, exp_r.fidx, exp_r.entry,
                                     exp_r.paddr, exp_r.ext);
                            $display("%0t          got f=%0d i=%0d e=%h p=%h x=%0d",
                                     $time, got.found, got.fidx, got.entry,
                                     got.paddr, got.ext);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0 && out_stall_pct > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (i_rst_n && $urandom_range(0, 99) < out_stall_pct) begin
            stall_left = $urandom_range(1, 13) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic issue_req(input t_row r);
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= r.act;
        i_entry_index  <= r.idx;
        i_new_physical <= r.newp;
        i_port_number  <= r.port;
        drv_typed      <= r.typed;
        drv_want       <= r.want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_own(input logic [ADDR_W-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0] nz_nib();
        return 4'($urandom_range(1, 15));
    endfunction

    initial begin
        t_row              r;
        logic [ADDR_W-1:0] own;
        int                pick;

        directed.push_back(op_chk(ACT_READ,   0, 16'h1234, 0, '{0, 0, 16'hFFFF, 16'hFFFF, 0}));
        directed.push_back(op_chk(ACT_LOOKUP, 9, 16'h0000, 1, '{0, 0, 16'hFFFF, 16'hFFFF, 0}));
        directed.push_back(op_chk(ACT_WRITE, 15, 16'h0000, 15, '{0, 0, 16'h0000, 16'hFFFF, 0}));
        directed.push_back(op_chk(ACT_WRITE,  0, 16'hFFFF, 0, '{0, 0, 16'hFFFF, 16'hFFFF, 0}));
        directed.push_back(op_chk(ACT_REMOVE, 15, 16'hFFFF, 0, '{0, 0, 16'hFFFF, 16'hFFFF, 0}));
        directed.push_back(op(ACT_WRITE, 3, 16'hABCD, 7));
        directed.push_back(op(ACT_READ,  3, 16'h5555, 8));
        directed.push_back(own_row(16'h0000));
        directed.push_back(op_chk(ACT_LOOKUP, 3, 16'h0000, 0, '{0, 0, 16'hABCD, 16'h0000, 1}));
        directed.push_back(op(ACT_WRITE, 5, 16'h3000, 2));
        directed.push_back(op_chk(ACT_LOOKUP, 5, 16'h0000, 3, '{1, 5, 16'h3000, 16'h3000, 1}));
        directed.push_back(op(ACT_WRITE, 2, 16'h3000, 0));
        directed.push_back(op(ACT_LOOKUP, 0, 16'hFFFF, 3));
        directed.push_back(op(ACT_LOOKUP, 0, 16'h0000, 15));
        directed.push_back(own_row(16'h1000));
        directed.push_back(op(ACT_WRITE, 7, 16'h1F00, 1));
        directed.push_back(op_chk(ACT_LOOKUP, 7, 16'h0000, 15, '{1, 7, 16'h1F00, 16'h1F00, 1}));
        directed.push_back(op(ACT_LOOKUP, 1, 16'h0000, 0));
        directed.push_back(own_row(16'h1200));
        directed.push_back(op(ACT_WRITE, 8, 16'h1200, 0));
        directed.push_back(op(ACT_LOOKUP, 8, 16'h0000, 0));
        directed.push_back(own_row(16'h1230));
        directed.push_back(op(ACT_WRITE, 9, 16'h1234, 0));
        directed.push_back(op(ACT_LOOKUP, 4, 16'h0000, 4));
        directed.push_back(own_row(16'h1234));
        directed.push_back(op_chk(ACT_LOOKUP, 0, 16'h0000, 4, '{0, 0, 16'hFFFF, 16'hFFFF, 0}));
        directed.push_back(own_row(16'h0100));
        directed.push_back(op_chk(ACT_LOOKUP, 2, 16'h0000, 1, '{0, 0, 16'h3000, 16'hFFFF, 0}));
        // derived address comes out FFFF: must not match disabled entries
        directed.push_back(own_row(16'hFFF0));
        directed.push_back(op_chk(ACT_LOOKUP, 0, 16'h0000, 15, '{0, 0, 16'hFFFF, 16'hFFFF, 1}));
        directed.push_back(op(ACT_REMOVE, 5, 16'h0000, 0));
        directed.push_back(op(ACT_READ, 5, 16'h0000, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_gap_pct = 20;
        out_stall_pct = 10;
        foreach (directed[n]) begin
            if (directed[n].kind == ROW_OWN) write_own(directed[n].newp);
            else issue_req(directed[n]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            pick = (ph < 6) ? ph : $urandom_range(0, 5);
            case (pick)
                0: own = 16'h0000;
                1: own = 16'hFFFF;
                2: own = {nz_nib(), 12'h000};
                3: own = {nz_nib(), nz_nib(), 8'h00};
                4: own = {nz_nib(), nz_nib(), nz_nib(), 4'h0};
                default: own = 16'($urandom);
            endcase
            write_own(own);
            case (ph % 3)
                0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
                1: begin in_gap_pct = 15; out_stall_pct = 10; end
                default: begin in_gap_pct = 40; out_stall_pct = 30; end
            endcase
            if (ph == PHASES - 1) begin
                in_gap_pct = 0;
                out_stall_pct = 0;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 4 && n == PHASE_LEN / 2) drain();
                r = '0;
                r.kind = ROW_REQ;
                pick = $urandom_range(0, 99);
                if (pick < 30)      r.act = ACT_WRITE;
                else if (pick < 40) r.act = ACT_REMOVE;
                else if (pick < 75) r.act = ACT_LOOKUP;
                else                r.act = ACT_READ;
                r.idx = 4'($urandom_range(0, 15));
                r.port = 4'($urandom_range(0, 15));
                pick = $urandom_range(0, 99);
                if (pick < 45)      r.newp = child_addr(own, 4'($urandom_range(0, 15)));
                else if (pick < 50) r.newp = 16'h0000;
                else if (pick < 55) r.newp = 16'hFFFF;
                else                r.newp = 16'($urandom);
                issue_req(r);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        errors += pending_results.size();
        $display("Ran %0d requests (%0d lookup hits) over %0d own-address settings",
                 requests, lookup_hits, own_settings);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
